[hdl/whn_pkg.sv]
//------------------------------------------------------------------------------
// whn_pkg: shared definitions for the word hash novelty core
// Default sizes, character constants, register map and the event type passed
// from the word splitter to the counter stage.
//------------------------------------------------------------------------------
package whn_pkg;

    // default store geometry
    localparam int WHN_TABLE_SIZE  = 128;
    localparam int WHN_COUNT_WIDTH = 16;

    // character handling
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [6:0] HASH_MUL   = 7'd123;
    localparam int         DIGIT_ZERO = 48;

    localparam logic [7:0] NOVELTY_MAX = 8'hFF;

    // register map
    localparam int          APB_DATA_W          = 32;
    localparam int          APB_ADDR_W          = 2;
    localparam logic [APB_ADDR_W-1:0] REG_NOVELTY_EN_ADDR = 2'd0;

    // one stage-1 item as seen by the counter stage
    typedef struct packed {
        logic valid;
        logic word_end;
        logic msg_last;
    } whn_evt_t;

endpackage

[hdl/whn_hash_mod.sv]
//------------------------------------------------------------------------------
// whn_hash_mod: one step of the word hash
// r = (h*123 + (b|32) - 48) mod TABLE_SIZE, remainder kept non-negative.
// Power-of-two sizes reduce by masking; other sizes use a constant
// reciprocal multiply followed by a single compare and subtract.
//------------------------------------------------------------------------------
module whn_hash_mod
    import whn_pkg::*;
#(
    parameter int TABLE_SIZE = WHN_TABLE_SIZE
)
(
    input  logic [$clog2(TABLE_SIZE)-1:0] hash_in,
    input  logic [7:0]                    char_in,
    output logic [$clog2(TABLE_SIZE)-1:0] hash_out
);

    localparam int HW = $clog2(TABLE_SIZE);
    // h*123 + 255 + (TABLE_SIZE-1) stays below 2**UW
    localparam int UW = HW + 7;
    // -48 folded into a non-negative offset of the same residue
    localparam int NEG_OFS_I = (TABLE_SIZE - (DIGIT_ZERO % TABLE_SIZE)) % TABLE_SIZE;
    localparam logic [UW-1:0] NEG_OFS = UW'(NEG_OFS_I);
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    logic [UW-1:0] sum;

    assign sum = UW'(hash_in) * UW'(HASH_MUL) + UW'(char_in | CASE_BIT) + NEG_OFS;

    if (IS_POW2)
    begin : g_pow2
        assign hash_out = sum[HW-1:0];
    end
    else
    begin : g_recip
        localparam int SH = UW + HW;
        localparam logic [63:0] RECIP_W = (64'd1 << SH) / 64'(TABLE_SIZE);
        localparam logic [UW:0] RECIP = RECIP_W[UW:0];
        localparam logic [UW-1:0] TSIZE = UW'(TABLE_SIZE);

        logic [2*UW:0]  prod;
        logic [UW-HW:0] quot;
        logic [UW-1:0]  rem;

        // quotient is exact or one short
        assign prod = {{UW{1'b0}}, 1'b0, sum} * {{UW{1'b0}}, RECIP};
        assign quot = prod[2*UW:SH];
        assign rem  = sum - UW'(quot) * TSIZE;
        assign hash_out = (rem >= TSIZE) ? HW'(rem - TSIZE) : rem[HW-1:0];
    end

endmodule

[hdl/whn_splitter.sv]
//------------------------------------------------------------------------------
// whn_splitter: input register and word splitter
// Holds the accepted byte, advances the running word hash and flags word ends
// together with the counter slot of the finished word.
//------------------------------------------------------------------------------
module whn_splitter
    import whn_pkg::*;
#(
    parameter int TABLE_SIZE = WHN_TABLE_SIZE
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    char_byte,
    input  logic                          msg_last,
    input  logic                          adv,
    input  logic                          clearing,
    output whn_evt_t                      evt,
    output logic [$clog2(TABLE_SIZE)-1:0] slot
);

    localparam int HW = $clog2(TABLE_SIZE);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;
    logic [HW-1:0] hash_reg;
    logic [HW-1:0] hash_next;
    logic          in_word_reg;
    logic          in_word_next;
    logic [HW-1:0] hash_step;
    logic          take;

    assign in_ready = adv && !clearing;
    assign take     = in_valid && in_ready;

    whn_hash_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .hash_in  (hash_reg),
        .char_in  (s1_byte_reg),
        .hash_out (hash_step)
    );

    always_comb
    begin
        evt.valid    = s1_valid_reg;
        evt.msg_last = s1_last_reg;
        evt.word_end = 1'b0;
        slot         = hash_reg;
        hash_next    = hash_reg;
        in_word_next = in_word_reg;
        if (s1_byte_reg == SPACE_BYTE)
        begin
            // a space closes an open word; runs of spaces do nothing
            evt.word_end = in_word_reg;
            hash_next    = '0;
            in_word_next = 1'b0;
        end
        else
        begin
            hash_next    = hash_step;
            in_word_next = 1'b1;
            if (s1_last_reg)
            begin
                evt.word_end = 1'b1;
                slot         = hash_step;
                hash_next    = '0;
                in_word_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hash_reg     <= '0;
            in_word_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            if (s1_valid_reg)
            begin
                hash_reg    <= hash_next;
                in_word_reg <= in_word_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= char_byte;
            s1_last_reg <= msg_last;
        end
    end

endmodule

[hdl/whn_counter.sv]
//------------------------------------------------------------------------------
// whn_counter: word counter store, novelty count and result register
// Read-modify-write of one saturating counter per word end, with a one-deep
// bypass for back-to-back updates, and a clearing sweep after reset.
//------------------------------------------------------------------------------
module whn_counter
    import whn_pkg::*;
#(
    parameter int TABLE_SIZE  = WHN_TABLE_SIZE,
    parameter int COUNT_WIDTH = WHN_COUNT_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  whn_evt_t                      evt,
    input  logic [$clog2(TABLE_SIZE)-1:0] slot,
    input  logic                          novelty_enable,
    output logic                          adv,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    unseen_words
);

    localparam int HW = $clog2(TABLE_SIZE);
    localparam logic [HW-1:0] LAST_IDX = HW'(TABLE_SIZE - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [TABLE_SIZE];

    whn_evt_t               s2_reg;
    logic [HW-1:0]          s2_slot_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   fwd_valid_reg;
    logic [HW-1:0]          fwd_slot_reg;
    logic [COUNT_WIDTH-1:0] fwd_cnt_reg;
    logic [7:0]             nov_reg;
    logic [7:0]             nov_next;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic                   clr_active_reg;
    logic [HW-1:0]          clr_idx_reg;

    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic                   commit;
    logic                   emit;
    logic                   nov_inc;
    logic                   mem_we;
    logic [HW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;

    // only a message end waiting on a full result register holds the pipe
    assign adv      = !(s2_reg.valid && s2_reg.msg_last && out_valid_reg && !out_ready);
    assign clearing = clr_active_reg;

    assign commit = adv && s2_reg.valid && s2_reg.word_end;
    assign emit   = adv && s2_reg.valid && s2_reg.msg_last;

    // previous update lands at the same edge as this read
    assign cur_cnt = (fwd_valid_reg && (fwd_slot_reg == s2_slot_reg)) ? fwd_cnt_reg
                                                                      : rd_data_reg;
    assign cnt_new = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

    assign nov_inc  = s2_reg.word_end && novelty_enable && (cur_cnt == '0)
                      && (nov_reg != NOVELTY_MAX);
    assign nov_next = nov_reg + {7'd0, nov_inc};

    assign mem_we = clr_active_reg || commit;
    assign mem_wa = clr_active_reg ? clr_idx_reg : s2_slot_reg;
    assign mem_wd = clr_active_reg ? '0 : cnt_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (adv)
        begin
            rd_data_reg <= mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            nov_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s2_reg        <= evt;
                fwd_valid_reg <= commit;
                if (s2_reg.valid)
                begin
                    nov_reg <= s2_reg.msg_last ? '0 : nov_next;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_slot_reg  <= slot;
            fwd_slot_reg <= s2_slot_reg;
            fwd_cnt_reg  <= cnt_new;
        end
        if (emit)
        begin
            out_data_reg <= nov_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign unseen_words = out_data_reg;

`ifndef SYNTH
    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s2_reg.valid)
        else $error("word event in flight during clearing sweep");

    a_result_from_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_reg.valid && s2_reg.msg_last))
        else $error("result raised without a message end");

    a_novelty_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (nov_reg == '0))
        else $error("novelty count not cleared after result");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s2_slot_reg) && $stable(rd_data_reg)))
        else $error("counter stage moved while stalled");
`endif

endmodule

[hdl/word_hash_histogram_novelty_core.sv]
//------------------------------------------------------------------------------
// word_hash_histogram_novelty_core: per-message unseen word counter
// Result path: last byte through input, counter stage and result registers.
// Throughput: one byte per cycle unless a message end waits for out_ready; the
// store has single read and write ports, bypassed for back-to-back word ends.
// Reset: a clearing sweep over all TABLE_SIZE entries zeroes the store, with
// in_ready low meanwhile; configuration writes are taken throughout.
//------------------------------------------------------------------------------
module word_hash_histogram_novelty_core
    import whn_pkg::*;
#(
    parameter int TABLE_SIZE  = WHN_TABLE_SIZE,
    parameter int COUNT_WIDTH = WHN_COUNT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_byte,
    input  logic                  msg_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            unseen_words
);

    localparam int HW = $clog2(TABLE_SIZE);

    logic          novelty_enable_reg;
    logic          adv;
    logic          clearing;
    whn_evt_t      evt;
    logic [HW-1:0] slot;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            novelty_enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr == REG_NOVELTY_EN_ADDR))
        begin
            novelty_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == REG_NOVELTY_EN_ADDR)
                    ? {{(APB_DATA_W-1){1'b0}}, novelty_enable_reg} : '0;

    whn_splitter #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_splitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .msg_last  (msg_last),
        .adv       (adv),
        .clearing  (clearing),
        .evt       (evt),
        .slot      (slot)
    );

    whn_counter #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt            (evt),
        .slot           (slot),
        .novelty_enable (novelty_enable_reg),
        .adv            (adv),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .unseen_words   (unseen_words)
    );

endmodule

[test/tb_word_hash_histogram_novelty_core.sv]
//------------------------------------------------------------------------------
// tb_word_hash_histogram_novelty_core: self-checking bench for the novelty core
// Streams bytes into the core and checks every unseen-word count that it
// returns against a cycle-free model of the hashed word counters. A short
// scripted sequence comes first, then random messages under three idling
// patterns with novelty counting switched off and on.
//------------------------------------------------------------------------------
module tb_word_hash_histogram_novelty_core;
    import whn_pkg::*;

    localparam int ITEMS_PER_PHASE = 275;
    localparam int QUIET_LIMIT     = 2000;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            char_byte = '0;
    logic                  msg_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            unseen_words;

    word_hash_histogram_novelty_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_byte    (char_byte),
        .msg_last     (msg_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .unseen_words (unseen_words)
    );

    // word counter model
    logic [WHN_COUNT_WIDTH-1:0] word_tally [WHN_TABLE_SIZE];
    int                         hash_now;
    bit                         word_open;
    logic [7:0]                 unseen_now;
    bit                         novelty_on;

    logic [7:0] unseen_due [$];
    int         fails = 0;
    int         send_gap_pct = 0;
    int         stall_pct = 0;
    int         quiet_cycles = 0;

    typedef struct {
        logic [7:0] chr;
        logic       last;
        bit         typed;
        logic [7:0] unseen;
    } script_row_t;

    // typed counts only where obvious; the rest come from the model
    script_row_t script [22] = '{
        '{8'h61, 1'b1, 1'b1, 8'd1},   // "a" straight after reset: fresh word
        '{8'h61, 1'b1, 1'b1, 8'd0},   // "a" again: already seen
        '{8'h20, 1'b1, 1'b1, 8'd0},   // lone space: no words
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b1, 1'b1, 8'd0},   // spaces only
        '{8'h00, 1'b0, 1'b0, 8'd0},   // zero byte, negative term
        '{8'hFF, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h01, 1'b1, 1'b0, 8'd0},   // last byte inside a word
        '{8'h62, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b1, 1'b0, 8'd0},   // last byte a trailing space
        '{8'h7F, 1'b0, 1'b0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0},
        '{8'hDF, 1'b1, 1'b0, 8'd0},
        '{8'h41, 1'b1, 1'b1, 8'd0},   // "A" folds onto "a"
        '{8'h30, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h61, 1'b0, 1'b0, 8'd0},
        '{8'h20, 1'b0, 1'b0, 8'd0},
        '{8'h30, 1'b1, 1'b0, 8'd0}    // repeat within one message
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_word();
        if (!word_open)
            return;
        if (novelty_on && word_tally[hash_now] == '0 && unseen_now != NOVELTY_MAX)
            unseen_now++;
        if (word_tally[hash_now] != '1)
            word_tally[hash_now]++;
        hash_now  = 0;
        word_open = 1'b0;
    endfunction

    function automatic bit predict_unseen(input logic [7:0] chr, input logic last,
                                          output logic [7:0] unseen);
        int acc;
        unseen = '0;
        if (chr == SPACE_BYTE)
            close_word();
        else
        begin
            acc = hash_now * int'(HASH_MUL) + int'(chr | CASE_BIT) - DIGIT_ZERO;
            hash_now  = ((acc % WHN_TABLE_SIZE) + WHN_TABLE_SIZE) % WHN_TABLE_SIZE;
            word_open = 1'b1;
        end
        if (!last)
            return 1'b0;
        close_word();
        unseen     = unseen_now;
        unseen_now = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: c = 8'h61 + 8'($urandom_range(0, 25));
            7:                   c = 8'h30 + 8'($urandom_range(0, 9));
            default:
            begin
                c = 8'($urandom_range(0, 255));
                if (c == SPACE_BYTE)
                    c = 8'h00;
            end
        endcase
        return c;
    endfunction

    task automatic send_char(input logic [7:0] chr, input logic last,
                             input bit typed = 1'b0, input logic [7:0] typed_unseen = '0);
        logic [7:0] unseen;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= chr;
        msg_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_unseen(chr, last, unseen))
            unseen_due.push_back(typed ? typed_unseen : unseen);
    endtask

    // mostly well-formed text, some spaces-only messages and raw byte noise
    task automatic send_message(output int sent);
        logic [7:0] msg [$];
        int         kind;
        int         words;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            repeat ($urandom_range(1, 8))
                msg.push_back(($urandom_range(0, 3) == 0) ? SPACE_BYTE
                                                          : 8'($urandom_range(0, 255)));
        end
        else if (kind < 20)
        begin
            repeat ($urandom_range(1, 3))
                msg.push_back(SPACE_BYTE);
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                msg.push_back(SPACE_BYTE);
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 5);
            for (int w = 0; w < words; w++)
            begin
                if (w != 0)
                    repeat ($urandom_range(1, 3))
                        msg.push_back(SPACE_BYTE);
                repeat ($urandom_range(1, 5))
                    msg.push_back(word_char());
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 2))
                    msg.push_back(SPACE_BYTE);
        end
        foreach (msg[i])
            send_char(msg[i], i == msg.size() - 1);
        sent = msg.size();
    endtask

    task automatic reg_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_novelty(input bit value);
        logic [APB_DATA_W-1:0] rd;
        reg_access(1'b1, REG_NOVELTY_EN_ADDR, APB_DATA_W'(value), rd);
        novelty_on = value;
        reg_access(1'b0, REG_NOVELTY_EN_ADDR, '0, rd);
        if (rd !== APB_DATA_W'(value))
        begin
            $error("novelty_enable readback: expected %0d, got %0d", value, rd);
            fails++;
        end
    endtask

    // register writes only once nothing is in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (unseen_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(input int pattern);
        case (pattern)
            0:       begin send_gap_pct = 25; stall_pct = 66; end
            1:       begin send_gap_pct = 66; stall_pct = 25; end
            default: begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    always @(posedge clk)
        out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : result_check
        logic [7:0] due;
        if (rst_n && out_valid && out_ready)
        begin
            if (unseen_due.size() == 0)
            begin
                $error("unseen_words: expected no result, got %0d", unseen_words);
                fails++;
            end
            else
            begin
                due = unseen_due.pop_front();
                if (unseen_words !== due)
                begin
                    $error("unseen_words mismatch: expected %0d, got %0d",
                           due, unseen_words);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("** word_hash_histogram_novelty_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                    sent;
        int                    total;
        logic [APB_DATA_W-1:0] rd;
        foreach (word_tally[i])
            word_tally[i] = '0;
        hash_now   = 0;
        word_open  = 1'b0;
        unseen_now = '0;
        novelty_on = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        reg_access(1'b0, REG_NOVELTY_EN_ADDR, '0, rd);
        if (rd !== APB_DATA_W'(1))
        begin
            $error("novelty_enable after reset: expected 1, got %0d", rd);
            fails++;
        end

        foreach (script[i])
            send_char(script[i].chr, script[i].last, script[i].typed, script[i].unseen);

        // each idling pattern with counting off, then on
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            set_idling(ph / 2);
            set_novelty(ph % 2);
            total = 0;
            while (total < ITEMS_PER_PHASE)
            begin
                send_message(sent);
                total += sent;
            end
        end

        drain();
        if (fails == 0)
            $display("** word_hash_histogram_novelty_core: PASSED **");
        else
            $display("** word_hash_histogram_novelty_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/whn_pkg.sv
hdl/whn_hash_mod.sv
hdl/whn_splitter.sv
hdl/whn_counter.sv
hdl/word_hash_histogram_novelty_core.sv
test/tb_word_hash_histogram_novelty_core.sv
